// ===== hw/rtl/swsc_pkg.sv =====
// shared types and constants for the sliding window sender control block
// no dependencies; compiled first
package swsc_pkg;

  // sequence width default and fixed field widths
  localparam int unsigned SEQ_BITS_DEF  = 32;
  localparam int unsigned CFG_IDX_BITS  = 1;
  localparam int unsigned CFG_DATA_BITS = 24;

  // window limits and reset values
  localparam logic [10:0] WIN_MIN            = 11'd1;
  localparam logic [10:0] WIN_MAX            = 11'd1024;
  localparam logic [10:0] WIN_RESET          = 11'd16;
  localparam logic [23:0] INIT_TIMEOUT_RESET = 24'd1000000;

  // timeout estimator constants, microseconds
  localparam logic [26:0] RTO_MAX   = 27'h7FF_FFFF;
  localparam logic [23:0] DEV_FLOOR = 24'd10000;

  // configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_WINDOW_SLOTS = 1'b0,
    CFG_INIT_TIMEOUT = 1'b1
  } cfg_idx_e;

  // event codes
  typedef enum logic [1:0] {
    CMD_ACK    = 2'd0,
    CMD_SEND   = 2'd1,
    CMD_TIMER  = 2'd2,
    CMD_SAMPLE = 2'd3
  } cmd_e;

  // input word
  typedef struct packed {
    cmd_e        command;
    logic [31:0] ack_number;
    logic        ack_flag;
    logic [31:0] receiver_window;
    logic [23:0] rtt_sample;
  } in_word_t;

  // result word
  typedef struct packed {
    logic        status;
    logic        send_valid;
    logic [31:0] send_seq;
    logic        is_retransmit;
    logic        restart_timer;
    logic [10:0] slots_released;
    logic [31:0] window_base;
    logic [10:0] effective_window;
    logic [26:0] timeout_us;
  } out_word_t;

  // sequence side of one result
  typedef struct packed {
    logic        status;
    logic        send_valid;
    logic [31:0] send_seq;
    logic        is_retransmit;
    logic        restart_timer;
    logic [10:0] slots_released;
    logic [31:0] window_base;
  } win_res_t;

  // estimator controls for one step
  typedef struct packed {
    logic update;
    logic handshake;
    logic cfg_load;
  } est_ctl_t;

endpackage

// ===== hw/rtl/swsc_stream_if.sv =====
// valid/ready stream channel carrying one word per handshake
// word type is a parameter, normally a struct from swsc_pkg
interface swsc_stream_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/swsc_rtt_est.sv =====
// retransmit timeout estimator: smoothed rtt, deviation and current timeout
// depends on swsc_pkg
module swsc_rtt_est
  import swsc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  est_ctl_t    ctl_i,
  input  logic [23:0] sample_i,
  input  logic [23:0] init_timeout_i,
  output logic [26:0] timeout_o
);

  logic [23:0] est_q, est_d;
  logic [23:0] dev_q, dev_d;
  logic [26:0] rto_q, rto_d;
  logic        have_q, have_d;

  logic [27:0] est_sum;
  logic [23:0] est_new;
  logic [23:0] diff;
  logic [26:0] dev_sum;
  logic [23:0] dev_new;
  logic [23:0] dev_fl;
  logic [27:0] rto_sum;
  logic [26:0] rto_new;

  // est = (7*est + s) >> 3
  assign est_sum = 28'({est_q, 3'b000}) - 28'(est_q) + 28'(sample_i);
  assign est_new = est_sum[26:3];

  // dev = (3*dev + |s - est|) >> 2
  assign diff    = (sample_i >= est_new) ? (sample_i - est_new) : (est_new - sample_i);
  assign dev_sum = 27'({dev_q, 1'b0}) + 27'(dev_q) + 27'(diff);
  assign dev_new = dev_sum[25:2];

  // rto = est + 4*max(dev, floor), saturated
  assign dev_fl  = (dev_new > DEV_FLOOR) ? dev_new : DEV_FLOOR;
  assign rto_sum = 28'(est_new) + 28'({dev_fl, 2'b00});
  assign rto_new = rto_sum[27] ? RTO_MAX : rto_sum[26:0];

  // next state
  always_comb begin
    est_d  = est_q;
    dev_d  = dev_q;
    rto_d  = rto_q;
    have_d = have_q;
    if (ctl_i.handshake) begin
      est_d  = sample_i;
      dev_d  = {2'b00, sample_i[23:2]};
      rto_d  = 27'({sample_i, 1'b0}) + 27'(sample_i);
      have_d = 1'b1;
    end else if (ctl_i.update) begin
      est_d  = est_new;
      dev_d  = dev_new;
      rto_d  = rto_new;
      have_d = 1'b1;
    end else if (ctl_i.cfg_load && !have_q) begin
      rto_d = 27'(init_timeout_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      est_q  <= '0;
      dev_q  <= '0;
      rto_q  <= 27'(INIT_TIMEOUT_RESET);
      have_q <= 1'b0;
    end else begin
      est_q  <= est_d;
      dev_q  <= dev_d;
      rto_q  <= rto_d;
      have_q <= have_d;
    end
  end

  // timeout after this step
  assign timeout_o = rto_d;

endmodule

// ===== hw/rtl/swsc_window.sv =====
// go-back-n window state: base, next sequence, duplicate ack tracking
// depends on swsc_pkg
module swsc_window
  import swsc_pkg::*;
#(
  parameter int unsigned SEQ_BITS = SEQ_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  in_word_t    word_i,
  input  logic [10:0] win_i,
  input  logic [10:0] ewin_i,
  output win_res_t    res_o
);

  logic [SEQ_BITS-1:0] base_q, base_d;
  logic [SEQ_BITS-1:0] next_q, next_d;
  logic [SEQ_BITS-1:0] prev_q, prev_d;
  logic [1:0]          dup_q, dup_d;

  logic [SEQ_BITS-1:0] ack_s;
  logic [SEQ_BITS-1:0] win_s;
  logic [SEQ_BITS-1:0] outstanding;
  logic [SEQ_BITS-1:0] ack_gap;
  logic [SEQ_BITS-1:0] outstanding_post;
  logic [SEQ_BITS-1:0] send_s;
  logic [1:0]          dup_inc;

  assign ack_s       = SEQ_BITS'(word_i.ack_number);
  assign win_s       = SEQ_BITS'(win_i);
  assign outstanding = next_q - base_q;
  assign ack_gap     = ack_s - base_q;
  assign dup_inc     = dup_q + 2'd1;

  // event decode and next state
  always_comb begin
    base_d           = base_q;
    next_d           = next_q;
    prev_d           = prev_q;
    dup_d            = dup_q;
    outstanding_post = outstanding;
    send_s           = '0;
    res_o            = '0;
    case (word_i.command)
      CMD_ACK: begin
        if (!word_i.ack_flag) begin
          res_o.status = 1'b1;
        end else begin
          // in-window ack moves the base
          if (ack_gap != '0 && ack_gap < win_s) begin
            if (outstanding < ack_gap) begin
              next_d = ack_s;
            end
            base_d                = ack_s;
            res_o.slots_released  = 11'(ack_gap);
            outstanding_post      = next_d - ack_s;
            if (outstanding_post != '0) begin
              res_o.restart_timer = 1'b1;
            end
          end
          // fast retransmit on third duplicate
          if (ack_s == prev_q) begin
            if (dup_inc == 2'd3) begin
              dup_d = 2'd0;
              if (outstanding_post != '0) begin
                res_o.send_valid    = 1'b1;
                send_s              = base_d;
                res_o.is_retransmit = 1'b1;
                res_o.restart_timer = 1'b1;
              end
            end else begin
              dup_d = dup_inc;
            end
          end else begin
            dup_d = 2'd0;
          end
          prev_d = ack_s;
        end
      end
      CMD_SEND: begin
        if (outstanding < win_s) begin
          res_o.send_valid = 1'b1;
          send_s           = next_q;
          if (outstanding == '0) begin
            res_o.restart_timer = 1'b1;
          end
          next_d = next_q + SEQ_BITS'(1);
        end
      end
      CMD_TIMER: begin
        if (outstanding != '0) begin
          res_o.send_valid    = 1'b1;
          send_s              = base_q;
          res_o.is_retransmit = 1'b1;
          res_o.restart_timer = 1'b1;
        end
      end
      CMD_SAMPLE: begin
        if (!word_i.ack_flag) begin
          res_o.status = 1'b1;
        end else begin
          res_o.slots_released = ewin_i;
        end
      end
      default: begin
        res_o.status = 1'b0;
      end
    endcase
    res_o.send_seq    = 32'(send_s);
    res_o.window_base = 32'(base_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      next_q <= '0;
      prev_q <= '1;
      dup_q  <= 2'd0;
    end else if (fire_i) begin
      base_q <= base_d;
      next_q <= next_d;
      prev_q <= prev_d;
      dup_q  <= dup_d;
    end
  end

endmodule

// ===== hw/rtl/sliding_window_sender_control.sv =====
// Go-back-n sender window control with fast retransmit and rtt-based timeout.
// Pipeline: an accepted word is held in the input register and its result is
// registered in the output register when that register is free. Throughput: one
// word per cycle unless out_if stalls; state updates when the input register drains.
// Reset: rst_ni resets window state, estimator and both pipeline valid bits at once.
// Configuration writes are taken in any cycle.
module sliding_window_sender_control
  import swsc_pkg::*;
#(
  parameter int unsigned SEQ_BITS = SEQ_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  swsc_stream_if.sink              in_if,
  swsc_stream_if.source            out_if,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i
);

  logic        s1_valid_q, s1_valid_d;
  in_word_t    s1_word_q;
  logic        out_valid_q, out_valid_d;
  out_word_t   out_word_q, out_word_d;
  logic [10:0] win_slots_q;

  logic        out_free;
  logic        s1_adv;
  logic        in_fire;
  logic [10:0] win_eff;
  logic [10:0] ewin;
  win_res_t    win_res;
  est_ctl_t    est_ctl;
  logic [26:0] timeout;

  // handshake and pipeline control
  assign out_free     = !out_valid_q || out_if.ready;
  assign s1_adv       = s1_valid_q && out_free;
  assign in_if.ready  = !s1_valid_q || out_free;
  assign in_fire      = in_if.valid && in_if.ready;
  assign s1_valid_d   = in_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);
  assign out_valid_d  = s1_adv ? 1'b1 : (out_if.ready ? 1'b0 : out_valid_q);
  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_word_q;

  // window register; the initial timeout write goes straight to the estimator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_slots_q <= WIN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WINDOW_SLOTS: win_slots_q <= cfg_data_i[10:0];
        default:          win_slots_q <= win_slots_q;
      endcase
    end
  end

  // clamp window, then take min with advertised window
  assign win_eff = (win_slots_q == '0) ? WIN_MIN :
                   (win_slots_q > WIN_MAX) ? WIN_MAX : win_slots_q;
  assign ewin    = (s1_word_q.receiver_window < 32'(win_eff)) ?
                   s1_word_q.receiver_window[10:0] : win_eff;

  // estimator controls
  assign est_ctl.update    = s1_adv && (s1_word_q.command == CMD_ACK) && s1_word_q.ack_flag;
  assign est_ctl.handshake = s1_adv && (s1_word_q.command == CMD_SAMPLE) &&
                             s1_word_q.ack_flag;
  assign est_ctl.cfg_load  = cfg_we_i && (cfg_idx_i == CFG_INIT_TIMEOUT);

  swsc_window #(
    .SEQ_BITS (SEQ_BITS)
  ) u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (s1_adv),
    .word_i (s1_word_q),
    .win_i  (win_eff),
    .ewin_i (ewin),
    .res_o  (win_res)
  );

  swsc_rtt_est u_rtt_est (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (est_ctl),
    .sample_i       (s1_word_q.rtt_sample),
    .init_timeout_i (cfg_data_i),
    .timeout_o      (timeout)
  );

  // assemble result word
  always_comb begin
    out_word_d.status           = win_res.status;
    out_word_d.send_valid       = win_res.send_valid;
    out_word_d.send_seq         = win_res.send_seq;
    out_word_d.is_retransmit    = win_res.is_retransmit;
    out_word_d.restart_timer    = win_res.restart_timer;
    out_word_d.slots_released   = win_res.slots_released;
    out_word_d.window_base      = win_res.window_base;
    out_word_d.effective_window = ewin;
    out_word_d.timeout_us       = timeout;
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_word_q <= in_if.data;
    end
    if (s1_adv) begin
      out_word_q <= out_word_d;
    end
  end

  // a rejected word never sends, frees slots or restarts the timer
  a_reject_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_word_q.status |->
      !out_word_q.send_valid && !out_word_q.restart_timer &&
      out_word_q.slots_released == '0)
    else $error("rejected word has side effects");

  // a retransmission is a send that restarts the timer
  a_retx_sends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_word_q.is_retransmit |->
      out_word_q.send_valid && out_word_q.restart_timer)
    else $error("retransmit without send or timer restart");

  // freed slots never exceed the largest window
  a_slots_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_word_q.slots_released <= WIN_MAX)
    else $error("slots released out of range");

  // a stalled input register keeps its word
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_free |=> s1_valid_q && $stable(s1_word_q))
    else $error("input register lost a stalled word");

endmodule
